[hw/rtl/belc_pkg.sv]
// Shared types, command codes and step limits for the box extent length correction block.
package belc_pkg;

    localparam int FRAC_BITS = 10;
    localparam int MIN_LENGTH_FULL = 5 << FRAC_BITS;
    localparam logic [15:0] MIN_LENGTH_RESET =
        (MIN_LENGTH_FULL > 65535) ? 16'hFFFF : 16'(MIN_LENGTH_FULL);

    // command codes
    localparam logic [1:0] CMD_POSE   = 2'd0;
    localparam logic [1:0] CMD_SIZE   = 2'd1;
    localparam logic [1:0] CMD_POINT  = 2'd2;
    localparam logic [1:0] CMD_FINISH = 2'd3;

    localparam int STEP_W = 5;

    // sequence steps
    localparam logic [STEP_W-1:0] POSE_LAST     = 5'd17;
    localparam logic [STEP_W-1:0] PT_CHK_GATE   = 5'd4;
    localparam logic [STEP_W-1:0] PT_CHK_X      = 5'd7;
    localparam logic [STEP_W-1:0] PT_CHK_Y      = 5'd10;
    localparam logic [STEP_W-1:0] PT_LAST       = 5'd13;
    localparam logic [STEP_W-1:0] FIN_DECIDE    = 5'd1;
    localparam logic [STEP_W-1:0] FIN_CORNER0   = 5'd7;
    localparam logic [STEP_W-1:0] FIN_MUL_X     = 5'd21;
    localparam logic [STEP_W-1:0] FIN_MUL_Y     = 5'd22;
    localparam logic [STEP_W-1:0] FIN_LAST      = 5'd23;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [23:0] coord_x;
        logic signed [23:0] coord_y;
        logic signed [23:0] coord_z;
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic               large_vehicle;
    } item_t;

    typedef struct packed {
        logic               corrected;
        logic signed [23:0] out_pos_x;
        logic signed [23:0] out_pos_y;
        logic [22:0]        out_length;
        logic signed [23:0] measured_extent;
    } result_t;

    typedef struct packed {
        logic              load;
        logic              run;
        logic [1:0]        cmd;
        logic [STEP_W-1:0] step;
        logic              emit;
    } ctl_t;

    typedef struct packed {
        logic pt_fail;
        logic corr;
    } sts_t;

endpackage

[hw/rtl/belc_ctrl.sv]
// Sequencer that steps the datapath through each command's word.
module belc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [1:0]            start_cmd,
    input  belc_pkg::sts_t        sts,
    output logic                  busy,
    output belc_pkg::ctl_t        ctl
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                          state_reg, state_next;
    logic [1:0]                    cmd_reg, cmd_next;
    logic [belc_pkg::STEP_W-1:0]   step_reg, step_next;
    logic                          last;
    logic                          emit;

    // decide where the current sequence ends
    always_comb
    begin
        last = 1'b0;
        emit = 1'b0;
        if (state_reg == ST_RUN)
        begin
            case (cmd_reg)
                belc_pkg::CMD_POSE:
                begin
                    last = (step_reg == belc_pkg::POSE_LAST);
                end
                belc_pkg::CMD_SIZE:
                begin
                    last = 1'b1;
                end
                belc_pkg::CMD_POINT:
                begin
                    last = (step_reg == belc_pkg::PT_LAST) ||
                           (sts.pt_fail && ((step_reg == belc_pkg::PT_CHK_GATE) ||
                                            (step_reg == belc_pkg::PT_CHK_X) ||
                                            (step_reg == belc_pkg::PT_CHK_Y)));
                end
                default:
                begin
                    if (((step_reg == belc_pkg::FIN_DECIDE) && !sts.corr) ||
                        (step_reg == belc_pkg::FIN_LAST))
                    begin
                        last = 1'b1;
                        emit = 1'b1;
                    end
                end
            endcase
        end
    end

    // advance state and step counter
    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_RUN;
                    cmd_next   = start_cmd;
                    step_next  = '0;
                end
            end
            default:
            begin
                if (last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cmd_reg   <= belc_pkg::CMD_POSE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
            step_reg  <= step_next;
        end
    end

    assign busy     = (state_reg == ST_RUN);
    assign ctl.load = (state_reg == ST_IDLE) && start;
    assign ctl.run  = (state_reg == ST_RUN);
    assign ctl.cmd  = cmd_reg;
    assign ctl.step = step_reg;
    assign ctl.emit = emit;

endmodule

[hw/rtl/belc_datapath.sv]
// Box state, shared multiply-accumulate unit and result register.
module belc_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  belc_pkg::item_t      item,
    input  belc_pkg::ctl_t       ctl,
    input  logic                 cfg_we,
    input  logic [15:0]          cfg_data,
    output belc_pkg::sts_t       sts,
    output belc_pkg::result_t    result,
    output logic                 result_valid
);

    belc_pkg::item_t      in_reg;
    logic signed [15:0]   rot_reg [0:8];
    logic signed [23:0]   centre_reg [0:2];
    logic signed [23:0]   size_reg [0:2];
    logic                 large_reg;
    logic signed [23:0]   emin_reg, emax_reg;
    logic                 any_reg;
    logic [15:0]          minl_reg;

    logic signed [52:0]   acc_reg, acc_next;
    logic signed [52:0]   nacc_reg, nacc_next;
    logic signed [52:0]   best_reg;
    logic signed [23:0]   lx_reg;
    logic signed [39:0]   ab_reg [0:5];
    logic signed [25:0]   p_reg;
    logic                 sxn_reg;
    logic signed [23:0]   ext_reg;
    logic                 corr_reg;
    logic signed [41:0]   mx_reg, my_reg;
    belc_pkg::result_t    res_reg;
    logic                 val_reg;

    logic signed [24:0]   d_c [0:2];
    logic signed [25:0]   mul_a, mul_b;
    logic signed [51:0]   prod;
    logic signed [52:0]   prod2, term;
    logic [4:0]           pose_code;
    logic [3:0]           pt_code;
    logic [3:0]           rix;
    logic [2:0]           fi;
    logic [4:0]           jfull;
    logic [3:0]           j4;
    logic [3:0]           jprev;
    logic [3:0]           pcode;
    logic [3:0]           prevcode;
    logic signed [41:0]   psum, pround;
    logic signed [25:0]   p_c;
    logic signed [25:0]   diff_c;
    logic signed [24:0]   minl_s;
    logic signed [24:0]   edif;
    logic signed [23:0]   ext_c;
    logic                 corr_c;
    logic                 pt_fail;
    logic                 cmp_hit;
    logic [1:0]           cmp_corner;
    belc_pkg::result_t    res_c;
    logic signed [52:0]   posx_s, posy_s;

    // quaternion component by code w, x, y, z
    function automatic logic signed [15:0] qsel(input belc_pkg::item_t it,
                                                input logic [1:0] idx);
        logic signed [15:0] q;
        case (idx)
            2'd0:    q = it.quat_w;
            2'd1:    q = it.quat_x;
            2'd2:    q = it.quat_y;
            default: q = it.quat_z;
        endcase
        return q;
    endfunction

    // product terms of each rotation entry: {first, second, negate}
    function automatic logic [4:0] pose_term(input logic [3:0] e, input logic half);
        logic [4:0] c;
        case ({e, half})
            5'b0000_0: c = {2'd2, 2'd2, 1'b1};
            5'b0000_1: c = {2'd3, 2'd3, 1'b1};
            5'b0001_0: c = {2'd1, 2'd2, 1'b0};
            5'b0001_1: c = {2'd0, 2'd3, 1'b1};
            5'b0010_0: c = {2'd1, 2'd3, 1'b0};
            5'b0010_1: c = {2'd0, 2'd2, 1'b0};
            5'b0011_0: c = {2'd1, 2'd2, 1'b0};
            5'b0011_1: c = {2'd0, 2'd3, 1'b0};
            5'b0100_0: c = {2'd1, 2'd1, 1'b1};
            5'b0100_1: c = {2'd3, 2'd3, 1'b1};
            5'b0101_0: c = {2'd2, 2'd3, 1'b0};
            5'b0101_1: c = {2'd0, 2'd1, 1'b1};
            5'b0110_0: c = {2'd1, 2'd3, 1'b0};
            5'b0110_1: c = {2'd0, 2'd2, 1'b1};
            5'b0111_0: c = {2'd2, 2'd3, 1'b0};
            5'b0111_1: c = {2'd0, 2'd1, 1'b0};
            5'b1000_0: c = {2'd1, 2'd1, 1'b1};
            default:   c = {2'd2, 2'd2, 1'b1};
        endcase
        return c;
    endfunction

    // box-frame axis and point component for point steps: {axis, comp}
    function automatic logic [3:0] pt_map(input logic [4:0] s);
        logic [3:0] c;
        case (s)
            5'd4:    c = {2'd0, 2'd0};
            5'd5:    c = {2'd0, 2'd1};
            5'd6:    c = {2'd0, 2'd2};
            5'd7:    c = {2'd1, 2'd0};
            5'd8:    c = {2'd1, 2'd1};
            5'd9:    c = {2'd1, 2'd2};
            5'd10:   c = {2'd2, 2'd0};
            5'd11:   c = {2'd2, 2'd1};
            default: c = {2'd2, 2'd2};
        endcase
        return c;
    endfunction

    // corner and axis of one corner term: {corner, axis}
    function automatic logic [3:0] jsplit(input logic [3:0] j);
        logic [3:0] c;
        case (j)
            4'd0:    c = {2'd0, 2'd0};
            4'd1:    c = {2'd0, 2'd1};
            4'd2:    c = {2'd0, 2'd2};
            4'd3:    c = {2'd1, 2'd0};
            4'd4:    c = {2'd1, 2'd1};
            4'd5:    c = {2'd1, 2'd2};
            4'd6:    c = {2'd2, 2'd0};
            4'd7:    c = {2'd2, 2'd1};
            4'd8:    c = {2'd2, 2'd2};
            4'd9:    c = {2'd3, 2'd0};
            4'd10:   c = {2'd3, 2'd1};
            default: c = {2'd3, 2'd2};
        endcase
        return c;
    endfunction

    function automatic logic signed [52:0] rnd14(input logic signed [52:0] v);
        return (v + 53'sd8192) >>> 14;
    endfunction

    function automatic logic signed [52:0] rnd15(input logic signed [52:0] v);
        return (v + 53'sd16384) >>> 15;
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [52:0] v);
        logic signed [23:0] r;
        if (v > 53'sd8388607)
            r = 24'sh7FFFFF;
        else if (v < -53'sd8388608)
            r = 24'sh800000;
        else
            r = v[23:0];
        return r;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [52:0] v);
        logic signed [15:0] r;
        if (v > 53'sd32767)
            r = 16'sh7FFF;
        else if (v < -53'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    // box-frame coordinate beyond +-size/2 (both scaled by 2^14)
    function automatic logic outside(input logic signed [52:0] v,
                                     input logic signed [23:0] sz);
        logic signed [52:0] lim;
        logic signed [52:0] v2;
        lim = 53'(sz) <<< 14;
        v2  = v <<< 1;
        return (v2 < -lim) || (v2 > lim);
    endfunction

    // point offsets from the centre
    always_comb
    begin
        d_c[0] = 25'(in_reg.coord_x) - 25'(centre_reg[0]);
        d_c[1] = 25'(in_reg.coord_y) - 25'(centre_reg[1]);
        d_c[2] = 25'(in_reg.coord_z) - 25'(centre_reg[2]);
    end

    assign minl_s  = $signed({9'b0, minl_reg});
    assign fi      = 3'(ctl.step - 5'd1);
    assign jfull   = ctl.step - belc_pkg::FIN_CORNER0;
    assign j4      = jfull[3:0];
    assign jprev   = j4 - 4'd1;
    assign pose_code = pose_term(ctl.step[4:1], ctl.step[0]);
    assign pt_code   = pt_map(ctl.step);
    assign pcode     = jsplit(j4);
    assign prevcode  = jsplit(jprev);

    // length change toward the chosen corner side
    always_comb
    begin
        diff_c = 26'(size_reg[0]) - 26'(minl_s);
        if (sxn_reg)
            diff_c = -diff_c;
    end

    // select multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        rix   = '0;
        if (ctl.run)
        begin
            case (ctl.cmd)
                belc_pkg::CMD_POSE:
                begin
                    mul_a = 26'(qsel(in_reg, pose_code[4:3]));
                    mul_b = 26'(qsel(in_reg, pose_code[2:1]));
                end
                belc_pkg::CMD_POINT:
                begin
                    case (ctl.step)
                        5'd0:
                        begin
                            mul_a = 26'(d_c[0]);
                            mul_b = 26'(d_c[0]);
                        end
                        5'd1:
                        begin
                            mul_a = 26'(d_c[1]);
                            mul_b = 26'(d_c[1]);
                        end
                        5'd2:
                        begin
                            mul_a = 26'(size_reg[0]);
                            mul_b = 26'(size_reg[0]);
                        end
                        5'd3:
                        begin
                            mul_a = 26'(size_reg[1]);
                            mul_b = 26'(size_reg[1]);
                        end
                        default:
                        begin
                            rix   = 4'({2'b0, pt_code[1:0]} * 4'd3) + {2'b0, pt_code[3:2]};
                            mul_a = 26'(rot_reg[rix]);
                            mul_b = 26'(d_c[pt_code[1:0]]);
                        end
                    endcase
                end
                belc_pkg::CMD_FINISH:
                begin
                    if ((ctl.step >= 5'd1) && (ctl.step <= 5'd6))
                    begin
                        rix   = 4'({2'b0, fi[2:1]} * 4'd3) + {3'b0, fi[0]};
                        mul_a = 26'(rot_reg[rix]);
                        mul_b = fi[0] ? 26'(size_reg[1]) : 26'(size_reg[0]);
                    end
                    else if (ctl.step == belc_pkg::FIN_MUL_X)
                    begin
                        mul_a = 26'(rot_reg[0]);
                        mul_b = diff_c;
                    end
                    else if (ctl.step == belc_pkg::FIN_MUL_Y)
                    begin
                        mul_a = 26'(rot_reg[3]);
                        mul_b = diff_c;
                    end
                    else
                    begin
                        mul_a = p_reg;
                        mul_b = p_reg;
                    end
                end
                default:
                begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
    end

    assign prod  = mul_a * mul_b;
    assign prod2 = $signed({prod, 1'b0});
    assign term  = pose_code[0] ? -prod2 : prod2;

    // accumulate
    always_comb
    begin
        acc_next  = acc_reg;
        nacc_next = nacc_reg;
        case (ctl.cmd)
            belc_pkg::CMD_POSE:
            begin
                if (!ctl.step[0])
                begin
                    if ((ctl.step[4:1] == 4'd0) || (ctl.step[4:1] == 4'd4) ||
                        (ctl.step[4:1] == 4'd8))
                        acc_next = 53'sd268435456 + term;
                    else
                        acc_next = term;
                end
                else
                begin
                    acc_next = acc_reg + term;
                end
            end
            belc_pkg::CMD_POINT:
            begin
                case (ctl.step)
                    5'd0:    acc_next = 53'(prod);
                    5'd1:    acc_next = acc_reg + 53'(prod);
                    5'd2:    acc_next = acc_reg - 53'(prod);
                    5'd3:    acc_next = acc_reg - 53'(prod);
                    default:
                    begin
                        if (pt_code[1:0] == 2'd0)
                            acc_next = 53'(prod);
                        else
                            acc_next = acc_reg + 53'(prod);
                    end
                endcase
            end
            belc_pkg::CMD_FINISH:
            begin
                if ((ctl.step >= 5'd8) && (ctl.step <= 5'd19))
                begin
                    if (prevcode[1:0] == 2'd0)
                        nacc_next = 53'(prod);
                    else
                        nacc_next = nacc_reg + 53'(prod);
                end
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    // point gate and inside tests
    always_comb
    begin
        pt_fail = 1'b0;
        if (ctl.run && (ctl.cmd == belc_pkg::CMD_POINT))
        begin
            case (ctl.step)
                belc_pkg::PT_CHK_GATE: pt_fail = (acc_reg > 53'sd0);
                belc_pkg::PT_CHK_X:    pt_fail = outside(acc_reg, size_reg[0]);
                belc_pkg::PT_CHK_Y:    pt_fail = outside(acc_reg, size_reg[1]);
                belc_pkg::PT_LAST:     pt_fail = outside(acc_reg, size_reg[2]);
                default:               pt_fail = 1'b0;
            endcase
        end
    end

    // measured extent and correction decision
    always_comb
    begin
        edif   = 25'(emax_reg) - 25'(emin_reg);
        ext_c  = any_reg ? sat24(53'(edif)) : 24'sd0;
        corr_c = large_reg && (25'(size_reg[0]) >= minl_s) && (25'(ext_c) <= minl_s);
    end

    // corner position for one axis
    always_comb
    begin
        psum   = (pcode[2] ? -42'(ab_reg[{pcode[1:0], 1'b0}]) : 42'(ab_reg[{pcode[1:0], 1'b0}])) +
                 (pcode[3] ? -42'(ab_reg[{pcode[1:0], 1'b1}]) : 42'(ab_reg[{pcode[1:0], 1'b1}]));
        pround = (psum + 42'sd16384) >>> 15;
        p_c    = 26'(centre_reg[pcode[1:0]]) + $signed(pround[25:0]);
    end

    // corner norm comparisons
    always_comb
    begin
        cmp_hit    = 1'b0;
        cmp_corner = 2'd0;
        case (ctl.step)
            5'd11:   begin cmp_hit = 1'b1; cmp_corner = 2'd0; end
            5'd14:   begin cmp_hit = 1'b1; cmp_corner = 2'd1; end
            5'd17:   begin cmp_hit = 1'b1; cmp_corner = 2'd2; end
            5'd20:   begin cmp_hit = 1'b1; cmp_corner = 2'd3; end
            default: begin cmp_hit = 1'b0; cmp_corner = 2'd0; end
        endcase
    end

    // assemble the result word
    always_comb
    begin
        posx_s = 53'(centre_reg[0]) + rnd15(53'(mx_reg));
        posy_s = 53'(centre_reg[1]) + rnd15(53'(my_reg));
        res_c.corrected       = corr_reg;
        res_c.measured_extent = ext_reg;
        if (corr_reg)
        begin
            res_c.out_pos_x  = sat24(posx_s);
            res_c.out_pos_y  = sat24(posy_s);
            res_c.out_length = {7'b0, minl_reg};
        end
        else
        begin
            res_c.out_pos_x  = centre_reg[0];
            res_c.out_pos_y  = centre_reg[1];
            res_c.out_length = size_reg[0][23] ? 23'd0 : size_reg[0][22:0];
        end
    end

    // box state, extents and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 9; k++)
                rot_reg[k] <= (k % 4 == 0) ? 16'sd16384 : 16'sd0;
            for (int k = 0; k < 3; k++)
            begin
                centre_reg[k] <= '0;
                size_reg[k]   <= '0;
            end
            large_reg <= 1'b0;
            emin_reg  <= 24'sh7FFFFF;
            emax_reg  <= 24'sh800000;
            any_reg   <= 1'b0;
            minl_reg  <= belc_pkg::MIN_LENGTH_RESET;
            val_reg   <= 1'b0;
        end
        else
        begin
            val_reg <= ctl.emit;
            if (cfg_we)
                minl_reg <= cfg_data;
            if (ctl.run)
            begin
                case (ctl.cmd)
                    belc_pkg::CMD_POSE:
                    begin
                        if (ctl.step[0])
                            rot_reg[ctl.step[4:1]] <= sat16(rnd14(acc_next));
                        if (ctl.step == belc_pkg::POSE_LAST)
                        begin
                            centre_reg[0] <= in_reg.coord_x;
                            centre_reg[1] <= in_reg.coord_y;
                            centre_reg[2] <= in_reg.coord_z;
                            emin_reg <= 24'sh7FFFFF;
                            emax_reg <= 24'sh800000;
                            any_reg  <= 1'b0;
                        end
                    end
                    belc_pkg::CMD_SIZE:
                    begin
                        size_reg[0] <= in_reg.coord_x;
                        size_reg[1] <= in_reg.coord_y;
                        size_reg[2] <= in_reg.coord_z;
                        large_reg   <= in_reg.large_vehicle;
                    end
                    belc_pkg::CMD_POINT:
                    begin
                        if ((ctl.step == belc_pkg::PT_LAST) && !pt_fail)
                        begin
                            if (lx_reg < emin_reg)
                                emin_reg <= lx_reg;
                            if (lx_reg > emax_reg)
                                emax_reg <= lx_reg;
                            any_reg <= 1'b1;
                        end
                    end
                    default:
                    begin
                        if (ctl.emit)
                        begin
                            emin_reg <= 24'sh7FFFFF;
                            emax_reg <= 24'sh800000;
                            any_reg  <= 1'b0;
                        end
                    end
                endcase
            end
        end
    end

    // working registers and result word
    always_ff @(posedge clk)
    begin
        if (ctl.load)
            in_reg <= item;
        if (ctl.run)
        begin
            acc_reg  <= acc_next;
            nacc_reg <= nacc_next;
            if ((ctl.cmd == belc_pkg::CMD_POINT) && (ctl.step == belc_pkg::PT_CHK_X))
                lx_reg <= sat24(rnd14(acc_reg));
            if (ctl.cmd == belc_pkg::CMD_FINISH)
            begin
                if (ctl.step == 5'd0)
                begin
                    ext_reg  <= ext_c;
                    corr_reg <= corr_c;
                end
                if ((ctl.step >= 5'd1) && (ctl.step <= 5'd6))
                    ab_reg[fi] <= prod[39:0];
                if ((ctl.step >= belc_pkg::FIN_CORNER0) && (ctl.step <= 5'd18))
                    p_reg <= p_c;
                if (cmp_hit && ((cmp_corner == 2'd0) || (nacc_reg < best_reg)))
                begin
                    best_reg <= nacc_reg;
                    sxn_reg  <= cmp_corner[0];
                end
                if (ctl.step == belc_pkg::FIN_MUL_X)
                    mx_reg <= prod[41:0];
                if (ctl.step == belc_pkg::FIN_MUL_Y)
                    my_reg <= prod[41:0];
            end
        end
        if (ctl.emit)
            res_reg <= res_c;
    end

    assign sts.pt_fail  = pt_fail;
    assign sts.corr     = corr_reg;
    assign result       = res_reg;
    assign result_valid = val_reg;

endmodule

[hw/rtl/box_extent_length_correction_core.sv]
// Top level of the box extent length correction block.
//
//  channel   direction  handshake                  word
//  item      in         start && !busy             belc_pkg::item_t
//  result    out        result_valid, one cycle    belc_pkg::result_t
//  cfg       in         cfg_valid && cfg_ready     min_length, 16 bits
//
// One shared 26x26 multiplier does all the multiplications, stepped by the sequencer. busy
// stays high while a command's steps run; a point ends early when the planar gate or an
// inside test fails, and a finish runs all its steps only with correction; one idle cycle
// follows, at whose end the next word may be taken. The result word is shown for one
// cycle after the last step and cannot be held off by the receiver.
// Reset clears the box to identity rotation, zero centre and size, empty extent.
module box_extent_length_correction_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  belc_pkg::item_t      item,
    output logic                 result_valid,
    output belc_pkg::result_t    result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [15:0]          cfg_data
);

    belc_pkg::ctl_t ctl;
    belc_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    belc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .start_cmd (item.cmd),
        .sts       (sts),
        .busy      (busy),
        .ctl       (ctl)
    );

    belc_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .ctl          (ctl),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .sts          (sts),
        .result       (result),
        .result_valid (result_valid)
    );

`ifndef SYNTHESIS
    a_emit_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result strobe without a busy cycle before it");

    a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not start a sequence");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held for two cycles");
`endif

endmodule

[sim/box_extent_length_correction_core_tb.sv]
// Self-checking testbench for the box extent length correction core.
module box_extent_length_correction_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Box state and predictor for the length correction
    class extent_scoreboard;
        longint rot[9];
        longint ctr[3];
        longint bsize[3];
        bit big_box;
        longint emin, emax;
        bit seen;
        longint min_len;
        belc_pkg::result_t pending[$];
        int errors;
        int results_seen;

        function void reset_state();
            for (int k = 0; k < 9; k++) rot[k] = (k % 4 == 0) ? 16384 : 0;
            for (int k = 0; k < 3; k++)
            begin
                ctr[k] = 0;
                bsize[k] = 0;
            end
            big_box = 0;
            clear_extent();
            min_len = belc_pkg::MIN_LENGTH_RESET;
            errors = 0;
            results_seen = 0;
        endfunction

        function void clear_extent();
            emin = 8388607;
            emax = -8388608;
            seen = 0;
        endfunction

        function longint round_sh(longint v, int s);
            return (v + (longint'(1) << (s - 1))) >>> s;
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        // Fold one accepted input word into the box state
        function void note_item(belc_pkg::item_t it);
            longint w, x, y, z, q[9], d[3], v[3], lx;
            bit ok;
            case (it.cmd)
                belc_pkg::CMD_POSE:
                begin
                    w = it.quat_w; x = it.quat_x; y = it.quat_y; z = it.quat_z;
                    q[0] = (longint'(1) << 28) - 2 * (y * y + z * z);
                    q[1] = 2 * (x * y - w * z);
                    q[2] = 2 * (x * z + w * y);
                    q[3] = 2 * (x * y + w * z);
                    q[4] = (longint'(1) << 28) - 2 * (x * x + z * z);
                    q[5] = 2 * (y * z - w * x);
                    q[6] = 2 * (x * z - w * y);
                    q[7] = 2 * (y * z + w * x);
                    q[8] = (longint'(1) << 28) - 2 * (x * x + y * y);
                    for (int k = 0; k < 9; k++)
                        rot[k] = clip(round_sh(q[k], 14), -32768, 32767);
                    ctr[0] = it.coord_x; ctr[1] = it.coord_y; ctr[2] = it.coord_z;
                    clear_extent();
                end
                belc_pkg::CMD_SIZE:
                begin
                    bsize[0] = it.coord_x; bsize[1] = it.coord_y; bsize[2] = it.coord_z;
                    big_box = it.large_vehicle;
                end
                belc_pkg::CMD_POINT:
                begin
                    d[0] = longint'(it.coord_x) - ctr[0];
                    d[1] = longint'(it.coord_y) - ctr[1];
                    d[2] = longint'(it.coord_z) - ctr[2];
                    ok = (d[0] * d[0] + d[1] * d[1]) <=
                         (bsize[0] * bsize[0] + bsize[1] * bsize[1]);
                    for (int k = 0; k < 3; k++)
                    begin
                        v[k] = rot[k] * d[0] + rot[3 + k] * d[1] + rot[6 + k] * d[2];
                        if (2 * v[k] < -bsize[k] * 16384 || 2 * v[k] > bsize[k] * 16384)
                            ok = 0;
                    end
                    if (ok)
                    begin
                        lx = clip(round_sh(v[0], 14), -8388608, 8388607);
                        if (lx < emin) emin = lx;
                        if (lx > emax) emax = lx;
                        seen = 1;
                    end
                end
                default: pending = {pending, finish_box()};
            endcase
        endfunction

        function belc_pkg::result_t finish_box();
            belc_pkg::result_t r;
            longint len, wid, ext, px, py, olen, best, sx, n, p, diff;
            int sgx[4] = '{1, -1, 1, -1};
            int sgy[4] = '{1, 1, -1, -1};
            bit corr;
            len = bsize[0]; wid = bsize[1];
            ext = seen ? clip(emax - emin, -8388608, 8388607) : 0;
            px = ctr[0]; py = ctr[1]; olen = clip(len, 0, 8388607);
            corr = big_box && len >= min_len && ext <= min_len;
            if (corr)
            begin
                best = 0; sx = 1;
                for (int c = 0; c < 4; c++)
                begin
                    n = 0;
                    for (int k = 0; k < 3; k++)
                    begin
                        p = ctr[k] + round_sh(rot[k * 3] * sgx[c] * len
                                              + rot[k * 3 + 1] * sgy[c] * wid, 15);
                        n += p * p;
                    end
                    if (c == 0 || n < best)
                    begin
                        best = n;
                        sx = sgx[c];
                    end
                end
                diff = sx * (len - min_len);
                px = clip(ctr[0] + round_sh(rot[0] * diff, 15), -8388608, 8388607);
                py = clip(ctr[1] + round_sh(rot[3] * diff, 15), -8388608, 8388607);
                olen = min_len;
            end
            r.corrected = corr;
            r.out_pos_x = px[23:0];
            r.out_pos_y = py[23:0];
            r.out_length = olen[22:0];
            r.measured_extent = ext[23:0];
            clear_extent();
            return r;
        endfunction

        // Compare one result word with the oldest expectation
        function void check_result(belc_pkg::result_t got);
            belc_pkg::result_t want;
            results_seen++;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.corrected !== want.corrected)
                $display("%0t: corrected exp %0d got %0d", $time, want.corrected, got.corrected);
            if (got.out_pos_x !== want.out_pos_x)
                $display("%0t: out_pos_x exp %0d got %0d", $time, want.out_pos_x, got.out_pos_x);
            if (got.out_pos_y !== want.out_pos_y)
                $display("%0t: out_pos_y exp %0d got %0d", $time, want.out_pos_y, got.out_pos_y);
            if (got.out_length !== want.out_length)
                $display("%0t: out_length exp %0d got %0d", $time, want.out_length,
                         got.out_length);
            if (got.measured_extent !== want.measured_extent)
                $display("%0t: measured_extent exp %0d got %0d", $time,
                         want.measured_extent, got.measured_extent);
            if (got !== want) errors++;
        endfunction
    endclass

    logic clk, rst_n, start, busy, result_valid, cfg_valid, cfg_ready;
    belc_pkg::item_t item;
    belc_pkg::result_t result;
    logic [15:0] cfg_data;
    extent_scoreboard board;
    bit no_idle;
    int stall_cycles, words_in;

    box_extent_length_correction_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // Check results and watch for a stuck block
    always @(posedge clk)
    begin
        if (rst_n && result_valid) board.check_result(result);
        if (!rst_n || result_valid || (start && !busy) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > 20000)
        begin
            $display("box_extent_length_correction_core: mismatch");
            $finish;
        end
    end

    // Drive one word; hold start until it is taken, then drop it
    task automatic send_word(belc_pkg::item_t it);
        while (!no_idle && $urandom_range(99) < 29) @(negedge clk);
        item <= it;
        start <= 1;
        do @(posedge clk); while (busy);
        board.note_item(it);
        words_in++;
        @(negedge clk);
        start <= 0;
        @(negedge clk);
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_min_length(logic [15:0] v);
        drain();
        cfg_data <= v;
        cfg_valid <= 1;
        do @(posedge clk); while (!cfg_ready);
        board.min_len = v;
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    function automatic belc_pkg::item_t make_word(logic [1:0] c, longint x, longint y,
                                                  longint z);
        belc_pkg::item_t it;
        it = '0;
        it.cmd = c;
        it.coord_x = x[23:0]; it.coord_y = y[23:0]; it.coord_z = z[23:0];
        it.quat_w = 16384;
        return it;
    endfunction

    function automatic logic [15:0] rand_q();
        return 16'($signed($urandom_range(32768)) - 16384);
    endfunction

    function automatic longint rand_coord(int span);
        return longint'($urandom_range(2 * span)) - span;
    endfunction

    // One object: pose, size, a batch of points, finish
    task automatic send_object(int span);
        belc_pkg::item_t it;
        longint cx, cy, cz, len;
        int npts;
        it = make_word(belc_pkg::CMD_POSE, rand_coord(span), rand_coord(span),
                       rand_coord(span));
        if ($urandom_range(3) == 0)
        begin
            it.quat_w = rand_q(); it.quat_x = rand_q();
            it.quat_y = rand_q(); it.quat_z = rand_q();
        end
        else
        begin
            it.quat_w = 16'($urandom_range(16384));
            it.quat_z = 16'($signed($urandom_range(8000)) - 4000);
        end
        cx = it.coord_x; cy = it.coord_y; cz = it.coord_z;
        send_word(it);
        len = $urandom_range(3) == 0 ? $urandom_range(20000) : $urandom_range(3000, 9000);
        it = make_word(belc_pkg::CMD_SIZE, len, $urandom_range(4000), $urandom_range(5000));
        if ($urandom_range(15) == 0) it.coord_x = 24'($signed($urandom_range(4000)) - 2000);
        it.large_vehicle = $urandom_range(3) != 0;
        send_word(it);
        npts = $urandom_range(12);
        for (int p = 0; p < npts; p++)
            send_word(make_word(belc_pkg::CMD_POINT, cx + rand_coord(int'(len)),
                                cy + rand_coord(3000), cz + rand_coord(3000)));
        send_word(make_word(belc_pkg::CMD_FINISH, 0, 0, 0));
    endtask

    initial
    begin
        belc_pkg::item_t it;
        board = new();
        board.reset_state();
        rst_n = 0; start = 0; item = '0; cfg_valid = 0; cfg_data = '0;
        no_idle = 0; words_in = 0; stall_cycles = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: a point before any pose, empty finish, extremes of fields
        send_word(make_word(belc_pkg::CMD_POINT, 0, 0, 0));
        send_word(make_word(belc_pkg::CMD_FINISH, 0, 0, 0));
        it = make_word(belc_pkg::CMD_POSE, 8388607, -8388608, 0);
        it.quat_w = -16384; it.quat_x = 16384; it.quat_y = -16384; it.quat_z = 16384;
        send_word(it);
        it = make_word(belc_pkg::CMD_SIZE, 8388607, 8388607, -8388608);
        it.large_vehicle = 1;
        send_word(it);
        send_word(make_word(belc_pkg::CMD_POINT, -8388608, 8388607, -1));
        send_word(make_word(belc_pkg::CMD_FINISH, 0, 0, 0));
        it = make_word(belc_pkg::CMD_POSE, 10000, -3000, 0);
        send_word(it);
        it = make_word(belc_pkg::CMD_SIZE, 8000, 2000, 3000);
        it.large_vehicle = 1;
        send_word(it);
        // Points on and inside the box bounds, then a finish that does not correct
        send_word(make_word(belc_pkg::CMD_POINT, 14000, -2000, 1500));
        send_word(make_word(belc_pkg::CMD_POINT, 6000, -4000, -1500));
        send_word(make_word(belc_pkg::CMD_POINT, 10500, -3000, 0));
        send_word(make_word(belc_pkg::CMD_FINISH, 0, 0, 0));
        it = make_word(belc_pkg::CMD_POSE, -10000, 3000, 0);
        it.quat_w = 0; it.quat_z = 16384;
        send_word(it);
        send_word(make_word(belc_pkg::CMD_FINISH, 0, 0, 0));

        // Random objects across several register settings
        write_min_length(16'd0);
        for (int n = 0; n < 40; n++) send_object(8388607);
        write_min_length(16'hFFFF);
        for (int n = 0; n < 40; n++) send_object(50000);
        write_min_length(belc_pkg::MIN_LENGTH_RESET);
        no_idle = 1;
        for (int n = 0; n < 50; n++) send_object(30000);
        no_idle = 0;
        write_min_length(16'(2 ** $urandom_range(15)));
        for (int n = 0; n < 85; n++)
        begin
            if ($urandom_range(5) == 0)
            begin
                it = make_word(2'($urandom), rand_coord(8388607), rand_coord(8388607),
                               rand_coord(8388607));
                it.quat_w = rand_q(); it.quat_x = rand_q();
                it.quat_y = rand_q(); it.quat_z = rand_q();
                it.large_vehicle = 1'($urandom);
                send_word(it);
            end
            send_object(40000);
        end
        drain();

        $display("Run sent %0d words and checked %0d box results over five length settings",
                 words_in, board.results_seen);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("box_extent_length_correction_core: match");
        else
            $display("box_extent_length_correction_core: mismatch");
        $finish;
    end
endmodule
